// ----- design/rpr_pkg.sv -----
`default_nettype none
package rpr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LFSR_W     = 16;
  localparam int PAGE_W     = 7;
  localparam int HIT_W      = 20;
  localparam int FRAME_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd1;

  localparam logic [FRAME_W-1:0] FRAME_LIMIT_RST = 8'd128;
  localparam logic [LFSR_W-1:0]  SEED_RST        = 16'd1;
  localparam logic [LFSR_W-1:0]  LFSR_TAPS       = 16'hB400;
  localparam logic [HIT_W-1:0]   HIT_MAX         = 20'hFFFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_STEP,
    ST_MOD,
    ST_PROBE,
    ST_CHECK,
    ST_EVICT,
    ST_DONE
  } rpr_state_t;

  typedef struct packed {
    logic seed_load;
    logic advance;
    logic reduce;
  } rpr_vctl_t;

  function automatic logic [LFSR_W-1:0] seed_value(input logic [LFSR_W-1:0] s);
    seed_value = (s == '0) ? LFSR_W'(1) : s;
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = (v >> 1) ^ (v[0] ? LFSR_TAPS : '0);
    lfsr_step = (n == '0) ? LFSR_W'(1) : n;
  endfunction

endpackage
`default_nettype wire

// ----- design/rpr_ram.sv -----
`default_nettype none
module rpr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/rpr_victim.sv -----
`default_nettype none
module rpr_victim #(
  parameter int PAGES = 128
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rpr_pkg::rpr_vctl_t          ctl,
  input  wire logic [rpr_pkg::LFSR_W-1:0]  seed,
  output logic      [$clog2(PAGES)-1:0]    cand,
  output logic                             reduce_last
);
  import rpr_pkg::*;

  localparam int     AW    = $clog2(PAGES);
  localparam int     MW    = LFSR_W + 1;
  localparam int     PW    = LFSR_W + MW;
  localparam int     SH    = LFSR_W + AW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(PAGES) - 1) / longint'(PAGES);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [LFSR_W-1:0] rem_r, rem_nxt;
  logic [LFSR_W-1:0] quo_r, quo_nxt;
  logic              phase_r, phase_nxt;

  // The quotient is registered from a reciprocal multiply first, and then the remainder is computed from that quotient.
  always_comb begin
    lfsr_nxt  = lfsr_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    phase_nxt = phase_r;
    if (ctl.seed_load) begin
      lfsr_nxt = seed_value(seed);
    end else if (ctl.advance) begin
      lfsr_nxt  = lfsr_step(lfsr_r);
      rem_nxt   = lfsr_step(lfsr_r);
      phase_nxt = 1'b0;
    end else if (ctl.reduce) begin
      if (!phase_r) begin
        quo_nxt   = LFSR_W'((PW'(rem_r) * PW'(RECIP_M)) >> SH);
        phase_nxt = 1'b1;
      end else begin
        rem_nxt   = rem_r - LFSR_W'(quo_r * LFSR_W'(PAGES));
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= SEED_RST;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    phase_r <= phase_nxt;
  end

  assign cand        = rem_r[AW-1:0];
  assign reduce_last = phase_r;

endmodule
`default_nettype wire

// ----- design/random_page_replacement.sv -----
// A hit or a fill of a free frame goes from ST_IDLE through ST_LOOK to ST_DONE, an ignored page
// straight to ST_DONE. A miss that evicts makes random tries, each through ST_STEP, ST_PROBE
// and ST_CHECK, with ST_MOD (quotient, then remainder) before ST_PROBE when PAGES is not a
// power of two, and ends in ST_EVICT for the swap. Tries average about PAGES / frame_limit.
// One item is in flight at a time. After reset and after an item marked last_reference,
// a clearing pass sweeps the present map through its single write port before accepting more.
`default_nettype none
module random_page_replacement #(
  parameter int PAGES = 128
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [rpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rpr_pkg::PAGE_W-1:0]        in_page_number,
  input  wire logic                              in_last_reference,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic                                   out_evicted_valid,
  output logic      [rpr_pkg::PAGE_W-1:0]        out_evicted_page,
  output logic      [rpr_pkg::HIT_W-1:0]         out_hit_total
);
  import rpr_pkg::*;

  localparam int  AW   = $clog2(PAGES);
  localparam bit  POW2 = ((PAGES & (PAGES - 1)) == 0);
  localparam int  RW   = 13;

  rpr_state_t state_r, state_nxt;

  logic [FRAME_W-1:0] limit_r, limit_nxt;
  logic [FRAME_W-1:0] frames_r, frames_nxt;
  logic [HIT_W-1:0]   hits_r, hits_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [AW-1:0]      page_r, page_nxt;
  logic               last_r, last_nxt;
  logic               hit_r, hit_nxt;
  logic               evv_r, evv_nxt;
  logic [PAGE_W-1:0]  evp_r, evp_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic               ohit_r, ohit_nxt;
  logic               oevv_r, oevv_nxt;
  logic [PAGE_W-1:0]  oevp_r, oevp_nxt;
  logic [HIT_W-1:0]   otot_r, otot_nxt;

  logic [FRAME_W-1:0] limit_eff;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic               accept;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic               ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic               ram_rdata;

  rpr_vctl_t          vctl;
  logic [AW-1:0]      cand;
  logic               reduce_last;

  assign limit_eff = (limit_r == '0) ? FRAME_W'(1) : limit_r;
  assign in_addr   = AW'(in_page_number);
  assign in_range  = (RW'(in_page_number) < RW'(PAGES));
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;

  always_comb begin
    limit_nxt = limit_r;
    if (cfg_we && (cfg_index == REG_FRAME_LIMIT)) begin
      limit_nxt = cfg_wdata[FRAME_W-1:0];
    end
  end

  always_comb begin
    state_nxt  = state_r;
    frames_nxt = frames_r;
    hits_nxt   = hits_r;
    clr_nxt    = clr_r;
    page_nxt   = page_r;
    last_nxt   = last_r;
    hit_nxt    = hit_r;
    evv_nxt    = evv_r;
    evp_nxt    = evp_r;
    ovalid_nxt = ovalid_r;
    ohit_nxt   = ohit_r;
    oevv_nxt   = oevv_r;
    oevp_nxt   = oevp_r;
    otot_nxt   = otot_r;
    ram_we     = 1'b0;
    ram_waddr  = page_r;
    ram_wdata  = 1'b1;
    ram_raddr  = cand;
    vctl       = '0;
    vctl.seed_load = cfg_we && (cfg_index == REG_RANDOM_SEED);

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = 1'b0;
        if (clr_r == AW'(PAGES - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        ram_raddr = in_addr;
        if (accept) begin
          page_nxt  = in_addr;
          last_nxt  = in_last_reference;
          hit_nxt   = 1'b0;
          evv_nxt   = 1'b0;
          evp_nxt   = '0;
          state_nxt = in_range ? ST_LOOK : ST_DONE;
        end
      end
      ST_LOOK: begin
        if (ram_rdata) begin
          hit_nxt = 1'b1;
          if (hits_r != HIT_MAX) begin
            hits_nxt = hits_r + HIT_W'(1);
          end
          state_nxt = ST_DONE;
        end else if (frames_r < limit_eff) begin
          frames_nxt = frames_r + FRAME_W'(1);
          ram_we     = 1'b1;
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        vctl.advance = 1'b1;
        state_nxt    = POW2 ? ST_PROBE : ST_MOD;
      end
      ST_MOD: begin
        vctl.reduce = 1'b1;
        if (reduce_last) begin
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (ram_rdata) begin
          ram_we    = 1'b1;
          ram_waddr = cand;
          ram_wdata = 1'b0;
          evv_nxt   = 1'b1;
          evp_nxt   = PAGE_W'(cand);
          state_nxt = ST_EVICT;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_EVICT: begin
        ram_we    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_r || out_ready) begin
          ovalid_nxt = 1'b1;
          ohit_nxt   = hit_r;
          oevv_nxt   = evv_r;
          oevp_nxt   = evp_r;
          otot_nxt   = hits_r;
          if (last_r) begin
            frames_nxt = '0;
            hits_nxt   = '0;
            clr_nxt    = '0;
            state_nxt  = ST_CLEAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      limit_r  <= FRAME_LIMIT_RST;
      frames_r <= '0;
      hits_r   <= '0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      limit_r  <= limit_nxt;
      frames_r <= frames_nxt;
      hits_r   <= hits_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    page_r <= page_nxt;
    last_r <= last_nxt;
    hit_r  <= hit_nxt;
    evv_r  <= evv_nxt;
    evp_r  <= evp_nxt;
    ohit_r <= ohit_nxt;
    oevv_r <= oevv_nxt;
    oevp_r <= oevp_nxt;
    otot_r <= otot_nxt;
  end

  rpr_ram #(
    .WIDTH(1),
    .DEPTH(PAGES)
  ) u_present (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rpr_victim #(
    .PAGES(PAGES)
  ) u_victim (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (vctl),
    .seed        (cfg_wdata[LFSR_W-1:0]),
    .cand        (cand),
    .reduce_last (reduce_last)
  );

  assign out_valid         = ovalid_r;
  assign out_hit           = ohit_r;
  assign out_evicted_valid = oevv_r;
  assign out_evicted_page  = oevp_r;
  assign out_hit_total     = otot_r;

endmodule
`default_nettype wire
